FILE: rtl/core/ssbs_pkg.sv
// shared constants and types for the sorted store binary search block
`default_nettype none
package ssbs_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 31;
   localparam int POS_W   = 6;
   localparam int KIND_W  = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 2'd0,
      KIND_SEARCH = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_CMP,
      ST_SRCH_READ,
      ST_SRCH_CMP
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/core/sorted_store_binary_search.sv
// sorted store with binary search: top level, sequencer and entry memory
//
// The block keeps up to DEPTH (64) 31-bit values in ascending order in a
// single-port-write, single-port-read memory with a registered read. An
// append item walks down from the top of the filled region, moving each
// larger entry up one place, each move being a read, then a compare and
// write, and drops its value into the gap, holding req_stall high until
// the value is written.
// An append into an empty store is written in the cycle it is accepted, and
// an append into a full store is dropped. A search item runs a binary search
// in which each memory probe is a read, then a compare; req_stall stays high
// until the search ends, after at most log2(DEPTH)+1 probes, and it returns
// one item with found and the probe
// index (0 when not found). Clear empties the store in the cycle it is
// accepted; kind 3 is ignored. Only a search, or an append into a store that
// is neither empty nor full, occupies the sequencer. The result sits in an
// output register, so a new item can be taken while an earlier result still
// waits; a search that finishes while that register is still held waits for
// it to drain, which adds those cycles to its stall.
`default_nettype none
module sorted_store_binary_search (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ssbs_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [ssbs_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_found,
   output logic [ssbs_pkg::POS_W-1:0]        rsp_position
);
   import ssbs_pkg::*;

   // sequencer state
   state_type state_ff, state_in;

   // number of valid entries
   logic [CNT_W-1:0]   count_ff, count_in;
   // insert position walking down during an append
   logic [CNT_W-1:0]   idx_ff, idx_in;
   // value being appended or key being searched
   logic [VALUE_W-1:0] key_ff, key_in;
   // search window: left inclusive, hi exclusive (hi = right + 1)
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]   rsp_position_ff, rsp_position_in;

   // entry memory
   logic [VALUE_W-1:0] entry_mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;

   // shared conditions
   logic               req_take;
   logic               out_free;
   logic               store_full;
   logic               store_empty;
   logic [CNT_W-1:0]   idx_dec;
   logic [CNT_W-1:0]   mid_calc;
   logic               window_open;
   logic               probe_hit;
   logic               probe_less;
   logic               probe_more;

   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign store_full  = (count_ff == CNT_W'(DEPTH));
   assign store_empty = (count_ff == '0);
   assign idx_dec     = idx_ff - CNT_W'(1);
   // mid = left + (right - left) / 2 with right = hi - 1
   assign mid_calc    = left_ff + ((hi_ff - left_ff - CNT_W'(1)) >> 1);
   assign window_open = (left_ff < hi_ff);
   // 31-bit equal and less-than compares between the read entry and the key
   assign probe_hit   = (rd_data_ff == key_ff);
   assign probe_less  = (rd_data_ff < key_ff);
   assign probe_more  = !probe_hit && !probe_less;

   // only the idle sequencer takes items
   assign req_stall = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_kind)
                  KIND_APPEND: begin
                     if (!store_full && !store_empty) begin
                        state_in = ST_INS_READ;
                     end
                  end
                  KIND_SEARCH: begin
                     state_in = ST_SRCH_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INS_READ: begin
            // reached the bottom: drop the value at index 0
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (rd_data_ff > key_ff) begin
               state_in = ST_INS_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SRCH_READ: begin
            if (window_open) begin
               state_in = ST_SRCH_CMP;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SRCH_CMP: begin
            if (probe_hit) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_SRCH_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath, memory controls and result register
   always_comb begin
      count_in        = count_ff;
      idx_in          = idx_ff;
      key_in          = key_ff;
      left_in         = left_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rd_en           = 1'b0;
      rd_addr         = '0;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = key_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_kind)
                  KIND_APPEND: begin
                     key_in = req_value;
                     idx_in = count_ff;
                     if (!store_full && store_empty) begin
                        // first entry goes straight in
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = req_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_SEARCH: begin
                     key_in  = req_value;
                     left_in = '0;
                     hi_in   = count_ff;
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_INS_READ: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = key_ff;
               count_in = count_ff + CNT_W'(1);
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_dec[ADDR_W-1:0];
            end
         end
         ST_INS_CMP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[ADDR_W-1:0];
            if (rd_data_ff > key_ff) begin
               // move the larger entry up one place
               wr_data = rd_data_ff;
               idx_in  = idx_dec;
            end else begin
               wr_data  = key_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_SRCH_READ: begin
            if (window_open) begin
               rd_en   = 1'b1;
               rd_addr = mid_calc[ADDR_W-1:0];
               mid_in  = mid_calc;
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
            end
         end
         ST_SRCH_CMP: begin
            if (probe_hit) begin
               if (out_free) begin
                  rsp_valid_in    = 1'b1;
                  rsp_found_in    = 1'b1;
                  rsp_position_in = POS_W'(mid_ff);
               end
            end else if (probe_less) begin
               left_in = mid_ff + CNT_W'(1);
            end else if (probe_more) begin
               hi_in = mid_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      key_ff          <= key_in;
      left_ff         <= left_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule
`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench for the sorted store binary search block
module tb;
   import ssbs_pkg::*;

   // run limits, well above the slowest correct run (full-store appends, all idling)
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int CALM_ITEMS    = 120;
   localparam int SETTLE_CYCLES = 300;
   localparam bit [VALUE_W-1:0] VALUE_MAX = '1;

   typedef struct {
      kind_type         kind;
      bit [VALUE_W-1:0] value;
      bit               drain;   // hold this item until every search answer is back
   } request_type;

   typedef struct {
      bit             found;
      bit [POS_W-1:0] position;
   } answer_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind     = KIND_NONE;
   logic [VALUE_W-1:0]  req_value    = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic                rsp_found;
   logic [POS_W-1:0]    rsp_position;

   // items waiting to be sent, and search answers waiting to be seen
   request_type pending_requests[$];
   answer_type  expected_answers[$];

   // predictor state: sorted copy of the store
   bit [VALUE_W-1:0] sorted_copy [DEPTH];
   int               copy_count = 0;

   // generator's view of what the store will hold, used to pick hitting keys
   bit [VALUE_W-1:0] planned_store[$];
   int               planned_count = 0;

   int   total_requests = 0;
   int   sent_count     = 0;
   int   accepted_count = 0;
   int   answers_due    = 0;
   int   answers_seen   = 0;   // written with nonblocking assignments only
   int   send_gap       = 0;
   int   stall_left     = 0;
   logic calm           = 1'b0;
   int   error_count    = 0;
   int   cycle_count    = 0;

   sorted_store_binary_search DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("tb mismatch: %s (cycle %0d)", what, cycle_count);
      error_count++;
   endtask

   // insert keeping ascending order, equal values land after existing ones
   function automatic void insert_sorted(input bit [VALUE_W-1:0] v);
      int i;
      if (copy_count >= DEPTH) return;   // full store drops the append
      i = copy_count;
      while (i > 0 && sorted_copy[i-1] > v) begin
         sorted_copy[i] = sorted_copy[i-1];
         i--;
      end
      sorted_copy[i] = v;
      copy_count++;
   endfunction

   // classic binary search, stops at the first equal probe
   function automatic answer_type binary_search(input bit [VALUE_W-1:0] key);
      answer_type hit;
      int         lo;
      int         hi;
      int         mid;
      hit.found    = 1'b0;
      hit.position = '0;
      lo = 0;
      hi = copy_count - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (sorted_copy[mid] == key) begin
            hit.found    = 1'b1;
            hit.position = mid[POS_W-1:0];
            return hit;
         end else if (sorted_copy[mid] < key) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return hit;
   endfunction

   // update the predictor for one accepted item
   function automatic void predict_request(input kind_type k, input bit [VALUE_W-1:0] v);
      case (k)
         KIND_APPEND: insert_sorted(v);
         KIND_SEARCH: begin
            expected_answers.push_back(binary_search(v));
            answers_due++;
         end
         KIND_CLEAR: copy_count = 0;
         default: ;   // unused kind is ignored
      endcase
   endfunction

   function automatic void plan(input kind_type k, input bit [VALUE_W-1:0] v,
                                input bit drain = 1'b0);
      request_type r;
      r.kind  = k;
      r.value = v;
      r.drain = drain;
      pending_requests.push_back(r);
      if (k != KIND_NONE) planned_count++;
      case (k)
         KIND_APPEND: if (planned_store.size() < DEPTH) planned_store.push_back(v);
         KIND_CLEAR:  planned_store.delete();
         default: ;
      endcase
   endfunction

   // values from narrow ranges make duplicates, the wide range toggles every bit
   function automatic bit [VALUE_W-1:0] pick_value(input int range_mode);
      case (range_mode)
         0: return VALUE_W'($urandom_range(0, 15));
         1: return VALUE_W'($urandom_range(0, 1000));
         2: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return VALUE_MAX;
               2:       return VALUE_MAX - VALUE_W'(1);
               default: return VALUE_W'(1);
            endcase
         end
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   // half the keys hit a stored value, some sit right next to one
   function automatic bit [VALUE_W-1:0] pick_key(input int range_mode);
      int               r;
      bit [VALUE_W-1:0] k;
      r = $urandom_range(0, 9);
      if (planned_store.size() != 0 && r < 7) begin
         k = planned_store[$urandom_range(0, planned_store.size() - 1)];
         if (r == 5) return k + VALUE_W'(1);
         if (r == 6) return k - VALUE_W'(1);
         return k;
      end
      return pick_value(range_mode);
   endfunction

   // stimulus: directed items, then random fill and search phases
   initial begin : stimulus
      int fill;
      int range_mode;
      int phase;
      int target;

      // empty store, extremes, duplicates, misses on both sides, unused kind
      plan(KIND_SEARCH, '0);
      plan(KIND_SEARCH, VALUE_MAX);
      plan(KIND_NONE,   VALUE_MAX);
      plan(KIND_APPEND, VALUE_MAX);
      plan(KIND_APPEND, '0);
      plan(KIND_APPEND, VALUE_W'(5));
      plan(KIND_APPEND, VALUE_W'(5));
      plan(KIND_APPEND, VALUE_W'(3));
      plan(KIND_SEARCH, '0);
      plan(KIND_SEARCH, VALUE_MAX);
      plan(KIND_SEARCH, VALUE_W'(5));
      plan(KIND_SEARCH, VALUE_W'(4));
      plan(KIND_SEARCH, VALUE_W'(1));
      plan(KIND_NONE,   VALUE_W'(5));
      plan(KIND_SEARCH, VALUE_W'(3));
      plan(KIND_CLEAR,  VALUE_MAX);
      plan(KIND_SEARCH, VALUE_W'(5));
      plan(KIND_APPEND, VALUE_W'(1));
      plan(KIND_SEARCH, VALUE_W'(1));
      plan(KIND_SEARCH, VALUE_W'(2));
      plan(KIND_SEARCH, '0);
      plan(KIND_CLEAR,  '0);

      target = planned_count + RANDOM_ITEMS;
      phase  = 0;
      while (planned_count < target) begin
         range_mode = $urandom_range(0, 3);
         // first phase overfills the store so that appends get dropped
         if (phase == 0) begin
            fill = DEPTH + 2;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: fill = $urandom_range(0, 12);
               6, 7:             fill = $urandom_range(13, 40);
               default:          fill = DEPTH + $urandom_range(0, 3);
            endcase
         end
         // some phases start only once the block has fully drained
         plan(KIND_SEARCH, pick_key(range_mode), (phase % 5) == 1);
         for (int i = 0; i < fill; i++) begin
            plan(KIND_APPEND, pick_value(range_mode));
            if ($urandom_range(0, 2) == 0) plan(KIND_SEARCH, pick_key(range_mode));
            if ($urandom_range(0, 60) == 0) plan(KIND_NONE, VALUE_W'($urandom()));
            if ($urandom_range(0, 80) == 0) plan(KIND_CLEAR, VALUE_W'($urandom()));
         end
         repeat ($urandom_range(3, 10)) plan(KIND_SEARCH, pick_key(range_mode));
         // sometimes keep the contents so the next phase piles on top
         if ($urandom_range(0, 2) != 0) plan(KIND_CLEAR, VALUE_W'($urandom()));
         phase++;
      end
      total_requests = pending_requests.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // wait for every item to be taken and every answer to come back
      while (accepted_count < total_requests || answers_seen < answers_due)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_answers.size() != 0)
         report_mismatch($sformatf("%0d search answers never arrived",
                                   expected_answers.size()));
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // cycle counter with a hard stop
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   // driver: predict on acceptance, then offer the next item or idle
   always @(posedge clock) begin : driver
      request_type queued;
      bit          may_idle;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         // no idling in the last stretch, and every fourth block of 50 items
         may_idle = !calm && ((sent_count / 50) % 4 != 3);
         if (req_valid && !req_stall) begin
            predict_request(kind_type'(req_kind), req_value);
            accepted_count++;
         end
         // a stalled item stays put; otherwise the slot is free
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_requests[0].drain && answers_seen < answers_due) begin
               req_valid <= 1'b0;
            end else begin
               queued = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_kind  <= queued.kind;
               req_value <= queued.value;
               sent_count++;
               if (may_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
            end
         end
         calm <= (sent_count >= total_requests - CALM_ITEMS);
      end
   end

   // monitor: compare each answer with the oldest prediction, stall in bursts
   always @(posedge clock) begin : monitor
      answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected item found=%0b position=%0d",
                                         rsp_found, rsp_position));
            end else begin
               want = expected_answers.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch($sformatf("found %0b, predicted %0b",
                                            rsp_found, want.found));
               if (rsp_position !== want.position)
                  report_mismatch($sformatf("position %0d, predicted %0d",
                                            rsp_position, want.position));
            end
            answers_seen <= answers_seen + 1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && ((answers_seen / 20) % 4 != 3) &&
                      $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule

FILE: filelist.f
rtl/core/ssbs_pkg.sv
rtl/core/sorted_store_binary_search.sv
sim/tb.sv
